>>> design/bmrect_pkg.sv
// Shared types, codes and helpers for the bitmap rectangle raster-op block
package bmrect_pkg;

  // default geometry
  localparam int GRID_SIZE_DEF = 1024;
  localparam int WORD_BITS_DEF = 64;

  // widest supported bitmap word and its popcount width
  localparam int WORD_MAX  = 64;
  localparam int POP_MAX_W = 7;

  // fixed field widths
  localparam int LIT_W      = 21;
  localparam int COORD_IN_W = 10;

  // operation codes
  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_INVERT = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // request beat
  typedef struct packed {
    logic [1:0]            operation;
    logic [COORD_IN_W-1:0] first_column;
    logic [COORD_IN_W-1:0] first_row;
    logic [COORD_IN_W-1:0] last_column;
    logic [COORD_IN_W-1:0] last_row;
  } bmrect_req_t;

  // response beat
  typedef struct packed {
    logic [LIT_W-1:0] lit_count;
    logic             inverted_corners;
  } bmrect_rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic mul;
    logic div_load_s;
    logic div_load_e;
    logic div_step;
    logic save_s;
    logic save_e;
    logic rd;
    logic wr;
    logic clr;
    logic wptr_inc;
    logic row_adv;
    logic res_load;
  } bmrect_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic item_skip;
    logic div_last;
    logic row_end;
    logic last_row;
    logic clr_last;
  } bmrect_sts_t;

  // number of set bits in a word
  function automatic logic [POP_MAX_W-1:0] popcount(input logic [WORD_MAX-1:0] w);
    logic [POP_MAX_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_MAX; i++) begin
      n = n + POP_MAX_W'(w[i]);
    end
    return n;
  endfunction

endpackage

>>> design/bmrect_datapath.sv
// Datapath: bitmap memory, corner-to-word divider, word walker, set-bit counter
module bmrect_datapath import bmrect_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  bmrect_req_t req,
  input  bmrect_cmd_t cmd,
  output bmrect_sts_t sts,
  output bmrect_rsp_t rsp
);

  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
  localparam int WORD_COUNT = (CELL_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int REM_W      = OFF_W + 1;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int COORD_W    = $clog2(GRID_SIZE);
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);
  localparam int POP_W      = $clog2(WORD_BITS + 1);
  localparam int ROW_Q      = GRID_SIZE / WORD_BITS;
  localparam int ROW_R      = GRID_SIZE % WORD_BITS;
  localparam int CMP_W      = ((COORD_IN_W > COORD_W) ? COORD_IN_W : COORD_W) + 1;
  // reciprocal of the word width, exact for every cell index
  localparam int DIV_SH     = IDX_W + OFF_W;
  localparam int RECIP_W    = IDX_W + 1;
  localparam int PROD_W     = IDX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << DIV_SH) + WORD_BITS - 1) / WORD_BITS);

  // saturate a coordinate to the grid
  function automatic logic [COORD_W-1:0] clamp(input logic [COORD_IN_W-1:0] v);
    if (CMP_W'(v) >= CMP_W'(GRID_SIZE)) begin
      return COORD_W'(GRID_SIZE - 1);
    end
    return COORD_W'(v);
  endfunction

  // item registers
  logic [1:0]         op;
  logic               inv;
  logic [COORD_W-1:0] col_lo;
  logic [COORD_W-1:0] col_hi;
  logic [COORD_W-1:0] row_lo;
  logic [COORD_W-1:0] row_hi;
  logic [COORD_W-1:0] row;

  // divider
  logic [IDX_W-1:0]  base;
  logic [IDX_W-1:0]  div_num;
  logic              div_cnt;
  logic [PROD_W-1:0] div_prod;
  logic [ADDR_W-1:0] div_quo;
  logic [IDX_W-1:0]  div_back;
  logic [IDX_W-1:0]  div_diff;
  logic [OFF_W-1:0]  div_rem;

  // row segment ends as word and bit offset
  logic [ADDR_W-1:0] s_word;
  logic [ADDR_W-1:0] e_word;
  logic [OFF_W-1:0]  s_off;
  logic [OFF_W-1:0]  e_off;
  logic [ADDR_W-1:0] wptr;
  logic [REM_W-1:0]  s_sum;
  logic [REM_W-1:0]  e_sum;
  logic              s_wrap;
  logic              e_wrap;
  logic [ADDR_W-1:0] s_word_adv;
  logic [ADDR_W-1:0] e_word_adv;
  logic [OFF_W-1:0]  s_off_adv;
  logic [OFF_W-1:0]  e_off_adv;

  // memory and read-modify-write
  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] mem_q;
  logic [WORD_BITS-1:0] mask_r;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] lo_m;
  logic [WORD_BITS-1:0] hi_m;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] wdata;
  logic                 we;

  // counter
  logic [POP_W-1:0] pop_old;
  logic [POP_W-1:0] pop_new;
  logic             pend;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] total_next;

  // status toward the controller
  always_comb begin
    sts.item_skip = (req.first_column > req.last_column) ||
                    (req.first_row > req.last_row) ||
                    (req.operation == OP_UNUSED);
    sts.div_last  = div_cnt;
    sts.row_end   = (wptr == e_word);
    sts.last_row  = (row == row_hi);
    sts.clr_last  = (wptr == ADDR_W'(WORD_COUNT - 1));
  end

  // quotient and remainder by the word width from the reciprocal product
  always_comb begin
    div_quo  = div_prod[DIV_SH +: ADDR_W];
    div_back = IDX_W'(div_quo) * IDX_W'(WORD_BITS);
    div_diff = div_num - div_back;
    div_rem  = div_diff[OFF_W-1:0];
  end

  // step both segment ends down one row
  always_comb begin
    s_sum      = {1'b0, s_off} + REM_W'(ROW_R);
    e_sum      = {1'b0, e_off} + REM_W'(ROW_R);
    s_wrap     = (s_sum >= REM_W'(WORD_BITS));
    e_wrap     = (e_sum >= REM_W'(WORD_BITS));
    s_off_adv  = OFF_W'(s_wrap ? (s_sum - REM_W'(WORD_BITS)) : s_sum);
    e_off_adv  = OFF_W'(e_wrap ? (e_sum - REM_W'(WORD_BITS)) : e_sum);
    s_word_adv = s_word + ADDR_W'(ROW_Q) + ADDR_W'(s_wrap);
    e_word_adv = e_word + ADDR_W'(ROW_Q) + ADDR_W'(e_wrap);
  end

  // bits of the current word inside the row segment
  always_comb begin
    lo_m = (wptr == s_word) ? ({WORD_BITS{1'b1}} << s_off) : {WORD_BITS{1'b1}};
    hi_m = (wptr == e_word) ? ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - e_off))
                            : {WORD_BITS{1'b1}};
    mask = lo_m & hi_m;
  end

  // apply the raster op
  always_comb begin
    case (op)
      OP_SET:    new_word = mem_q | mask_r;
      OP_CLEAR:  new_word = mem_q & ~mask_r;
      OP_INVERT: new_word = mem_q ^ mask_r;
      default:   new_word = mem_q;
    endcase
    wdata = cmd.clr ? '0 : new_word;
    we    = cmd.clr || cmd.wr;
  end

  // count follows the last written word
  assign total_next = pend ? (total - CNT_W'(pop_old) + CNT_W'(pop_new)) : total;

  // bitmap memory, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wptr] <= wdata;
    end
    if (cmd.rd) begin
      mem_q  <= mem[wptr];
      mask_r <= mask;
    end
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      pend  <= 1'b0;
      total <= '0;
    end else begin
      pend  <= cmd.wr;
      total <= total_next;
      if (cmd.save_e) begin
        wptr <= s_word;
      end else if (cmd.row_adv) begin
        wptr <= s_word_adv;
      end else if (cmd.wptr_inc) begin
        wptr <= wptr + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    // capture the request beat
    if (cmd.load_item) begin
      op     <= req.operation;
      inv    <= (req.first_column > req.last_column) || (req.first_row > req.last_row);
      col_lo <= clamp(req.first_column);
      col_hi <= clamp(req.last_column);
      row_lo <= clamp(req.first_row);
      row_hi <= clamp(req.last_row);
      row    <= clamp(req.first_row);
    end else if (cmd.row_adv) begin
      row <= row + 1'b1;
    end
    // first row base index
    if (cmd.mul) begin
      base <= IDX_W'(row_lo) * IDX_W'(GRID_SIZE);
    end
    // divider: load the index, then form the reciprocal product
    if (cmd.div_load_s) begin
      div_num <= base + IDX_W'(col_lo);
      div_cnt <= 1'b0;
    end else if (cmd.div_load_e) begin
      div_num <= base + IDX_W'(col_hi);
      div_cnt <= 1'b0;
    end else if (cmd.div_step) begin
      div_prod <= PROD_W'(div_num) * PROD_W'(RECIP);
      div_cnt  <= 1'b1;
    end
    // segment ends
    if (cmd.save_s) begin
      s_word <= div_quo;
      s_off  <= div_rem;
    end else if (cmd.row_adv) begin
      s_word <= s_word_adv;
      s_off  <= s_off_adv;
    end
    if (cmd.save_e) begin
      e_word <= div_quo;
      e_off  <= div_rem;
    end else if (cmd.row_adv) begin
      e_word <= e_word_adv;
      e_off  <= e_off_adv;
    end
    // popcounts of the word before and after the write
    if (cmd.wr) begin
      pop_old <= POP_W'(popcount(WORD_MAX'(mem_q)));
      pop_new <= POP_W'(popcount(WORD_MAX'(new_word)));
    end
    // response register
    if (cmd.res_load) begin
      rsp.lit_count        <= LIT_W'(total_next);
      rsp.inverted_corners <= inv;
    end
  end

  // count never exceeds the cell count
  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(CELL_COUNT))
    else $error("set-bit total beyond cell count");

  // a written word is always counted in the next cycle
  a_wr_counted: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |=> pend && !cmd.wr)
    else $error("count update lost or back-to-back write");

endmodule

>>> design/bmrect_ctrl.sv
// Controller: clear sweep, divider sequencing and word read-modify-write walk
module bmrect_ctrl import bmrect_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  input  bmrect_sts_t sts,
  output bmrect_cmd_t cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_LDS  = 4'd3;
  localparam logic [3:0] S_DIVS = 4'd4;
  localparam logic [3:0] S_DIVE = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_WR   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    req_stall  = (state != S_IDLE);
    case (state)
      S_CLR: begin
        cmd.clr      = 1'b1;
        cmd.wptr_inc = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = sts.item_skip ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_LDS;
      end
      S_LDS: begin
        cmd.div_load_s = 1'b1;
        state_next     = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.save_s     = 1'b1;
          cmd.div_load_e = 1'b1;
          state_next     = S_DIVE;
        end
      end
      S_DIVE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.save_e = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        if (!sts.row_end) begin
          cmd.wptr_inc = 1'b1;
          state_next   = S_RD;
        end else if (!sts.last_row) begin
          cmd.row_adv = 1'b1;
          state_next  = S_RD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // an accepted beat goes to setup or straight to the result
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> (state == S_MUL || state == S_FIN))
    else $error("bad state after request beat");

  // every write is followed by another read or by the result
  a_wr_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |=> (state == S_RD || state == S_FIN))
    else $error("bad state after word write");

  // the response register is only loaded when it is free
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!rsp_valid || !rsp_stall))
    else $error("response overwritten while held");

  // clear sweep runs until the last word
  a_clr_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR && !sts.clr_last) |=> (state == S_CLR))
    else $error("clear sweep left early");

endmodule

>>> design/bitmap_rectangle_set_clear_toggle_core.sv
// Top level of the bitmap rectangle set/clear/invert block
// A GRID_SIZE x GRID_SIZE one-bit bitmap is stored row-major, WORD_BITS cells per word, in
// one single-port memory; each request beat sets, clears or inverts an inclusive rectangle
// and each response beat returns the new set-cell count (low 21 bits) and a flag for
// inverted corners. After reset a clearing pass writes zero to every word, one word per
// cycle (16384 words at the defaults), and no request is taken until it ends. An item with
// inverted corners or the unused operation code leaves the bitmap as it is and goes
// straight to the result. Any other item steps through taking the beat, the row base,
// the first index, two corner-to-word divisions (each a reciprocal multiply, then the
// remainder), one read and one write on the memory port for each memory word touched,
// summed over the rectangle's rows, and the result. One item is in work at a time; the
// next request beat is taken while a finished response still waits.
module bitmap_rectangle_set_clear_toggle_core import bmrect_pkg::*; #(
  parameter int GRID_SIZE = GRID_SIZE_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  bmrect_req_t req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output bmrect_rsp_t rsp
);

  bmrect_cmd_t cmd;
  bmrect_sts_t sts;

  // sequencer
  bmrect_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // bitmap storage and arithmetic
  bmrect_datapath #(
    .GRID_SIZE (GRID_SIZE),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
